// ===== hw/rtl/sact_pkg.sv =====
// Shared types and constants of the set-associative cache tag store.
`default_nettype none

package sact_pkg;

  localparam int DEF_MAX_SETS = 64;
  localparam int DEF_WAYS     = 4;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int SETNUM_W   = 6;
  localparam int WAYNUM_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LOG2_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_SETS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 2'd2;

  localparam logic [3:0] RST_LOG2_BLOCK = 4'd6;
  localparam logic [2:0] RST_LOG2_SETS  = 3'd5;
  localparam logic [2:0] RST_WAYS_USED  = 3'd2;
  localparam logic [3:0] BLK_SHIFT_MAX  = 4'd12;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sact_row_mem.sv =====
// Set memory: one row of lines per set, one write port and one registered read port.
`default_nettype none

module sact_row_mem #(
  parameter int MAX_SETS = sact_pkg::DEF_MAX_SETS,
  parameter int WAYS     = sact_pkg::DEF_WAYS,
  parameter int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  wire                            clk,
  input  wire                            rd_en,
  input  wire  [SET_W-1:0]               rd_addr,
  output sact_pkg::line_t [WAYS-1:0]     rd_data,
  input  wire                            wr_en,
  input  wire  [SET_W-1:0]               wr_addr,
  input  wire  sact_pkg::line_t [WAYS-1:0] wr_data
);

  sact_pkg::line_t [WAYS-1:0] mem [MAX_SETS];
  sact_pkg::line_t [WAYS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sact_lookup.sv =====
// Tag match, LRU victim tournament and row update for one set.
`default_nettype none

module sact_lookup #(
  parameter int WAYS  = sact_pkg::DEF_WAYS,
  parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1,
  parameter int NW_W  = $clog2(WAYS + 1)
) (
  input  wire  sact_pkg::line_t [WAYS-1:0] row_i,
  input  wire  [sact_pkg::TAG_W-1:0]      tag_i,
  input  wire  [sact_pkg::STAMP_W-1:0]    stamp_i,
  input  wire  [NW_W-1:0]                 nw_i,
  output logic                            hit_o,
  output logic [WAY_W-1:0]                way_o,
  output sact_pkg::line_t [WAYS-1:0]      row_o
);

  localparam int LVL = (WAYS > 1) ? $clog2(WAYS) : 0;
  localparam int WP2 = 1 << LVL;

  logic                         in_use [WP2];
  logic                         c_use  [WP2];
  logic                         c_val  [WP2];
  logic [sact_pkg::STAMP_W-1:0] c_stamp[WP2];
  logic [WAY_W-1:0]             c_idx  [WP2];
  logic                         hit;
  logic [WAY_W-1:0]             hit_way;
  logic [WAY_W-1:0]             way;
  sact_pkg::line_t              fill;

  always_comb begin
    for (int i = 0; i < WP2; i++) begin
      in_use[i]  = 1'b0;
      c_use[i]   = 1'b0;
      c_val[i]   = 1'b0;
      c_stamp[i] = '0;
      c_idx[i]   = WAY_W'(i);
    end
    for (int w = 0; w < WAYS; w++) begin
      in_use[w]  = (NW_W'(w) < nw_i);
      c_use[w]   = in_use[w];
      c_val[w]   = row_i[w].valid;
      c_stamp[w] = row_i[w].stamp;
    end
    // Invalid lines win over valid ones, then the older stamp, then the lower way.
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < (WP2 >> 1); i++) begin
        if (i < (WP2 >> (l + 1))) begin
          if (c_use[2*i] && (!c_use[2*i+1] || !c_val[2*i] ||
              (c_val[2*i+1] && (c_stamp[2*i] <= c_stamp[2*i+1])))) begin
            c_use[i]   = c_use[2*i];
            c_val[i]   = c_val[2*i];
            c_stamp[i] = c_stamp[2*i];
            c_idx[i]   = c_idx[2*i];
          end else begin
            c_use[i]   = c_use[2*i+1];
            c_val[i]   = c_val[2*i+1];
            c_stamp[i] = c_stamp[2*i+1];
            c_idx[i]   = c_idx[2*i+1];
          end
        end
      end
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && row_i[w].valid && (row_i[w].tag == tag_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign way   = hit ? hit_way : c_idx[0];
  assign hit_o = hit;
  assign way_o = way;

  always_comb begin
    fill.valid = 1'b1;
    fill.tag   = tag_i;
    fill.stamp = stamp_i;
    for (int w = 0; w < WAYS; w++) begin
      row_o[w] = (way == WAY_W'(w)) ? fill : row_i[w];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/set_assoc_cache_tag_lru.sv =====
// Top level of the set-associative cache tag store with LRU replacement.
//
//   channel | direction | payload                                         | handshake
//   in      | input     | address                                         | in_valid/in_ready
//   out     | output    | hit, set_number, way_used, hit_total, miss_total | out_valid/out_ready
//   cfg     | input     | cfg_index, cfg_data                             | cfg_valid/cfg_ready
//
// Each access reads the set row from the set memory when it is accepted; the updated row
// is written back as the result is loaded into the output register.
// After reset a clearing pass writes MAX_SETS rows, one a cycle, while in_ready is low.
// A finished result waits in the output register; the next access is accepted
// meanwhile, and its write-back waits until the output register is free.
`default_nettype none

module set_assoc_cache_tag_lru #(
  parameter int MAX_SETS = sact_pkg::DEF_MAX_SETS,
  parameter int WAYS     = sact_pkg::DEF_WAYS
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [sact_pkg::ADDR_W-1:0]        in_address,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               out_hit,
  output logic [sact_pkg::SETNUM_W-1:0]      out_set_number,
  output logic [sact_pkg::WAYNUM_W-1:0]      out_way_used,
  output logic [sact_pkg::CNT_W-1:0]         out_hit_total,
  output logic [sact_pkg::CNT_W-1:0]         out_miss_total,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [sact_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [sact_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW_W   = $clog2(WAYS + 1);
  localparam int SS_LIM = $clog2(MAX_SETS + 1) - 1;
  localparam int SS_CAP = (SS_LIM > 7) ? 7 : SS_LIM;
  localparam logic [2:0]       SS_MAX    = 3'(SS_CAP);
  localparam logic [4:0]       WAYS5     = 5'(WAYS);
  localparam logic [SET_W-1:0] LAST_ROW  = SET_W'(MAX_SETS - 1);

  sact_pkg::state_t state_r, state_nxt;

  logic [3:0] cfg_blk_r, cfg_blk_nxt;
  logic [2:0] cfg_sets_r, cfg_sets_nxt;
  logic [2:0] cfg_ways_r, cfg_ways_nxt;

  logic [SET_W-1:0]             clr_idx_r, clr_idx_nxt;
  logic [SET_W-1:0]             set_idx_r;
  logic [sact_pkg::SETNUM_W-1:0] setnum_r;
  logic [sact_pkg::TAG_W-1:0]   tag_r;
  logic [sact_pkg::STAMP_W-1:0] acc_clk_r, acc_clk_nxt;
  logic [sact_pkg::CNT_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic [sact_pkg::CNT_W-1:0]   miss_cnt_r, miss_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r;
  logic [sact_pkg::SETNUM_W-1:0] out_set_r;
  logic [sact_pkg::WAYNUM_W-1:0] out_way_r;

  logic [3:0]                 bs;
  logic [2:0]                 ss;
  logic [4:0]                 ways5;
  logic [4:0]                 nw5;
  logic [NW_W-1:0]            nw;
  logic [31:0]                shifted;
  logic [31:0]                set_mask;
  logic [31:0]                set32;
  logic [sact_pkg::TAG_W-1:0] tag;
  logic [31:0]                way32;

  logic in_acc;
  logic done;
  logic clr_last;
  logic mem_wr_en;
  logic clearing;

  sact_pkg::line_t [WAYS-1:0] rd_row;
  sact_pkg::line_t [WAYS-1:0] new_row;
  sact_pkg::line_t [WAYS-1:0] wr_row;
  logic [SET_W-1:0]           wr_addr;
  logic                       lk_hit;
  logic [WAY_W-1:0]           lk_way;

  // Effective configuration.
  assign bs      = (cfg_blk_r > sact_pkg::BLK_SHIFT_MAX) ? sact_pkg::BLK_SHIFT_MAX : cfg_blk_r;
  assign ss      = (cfg_sets_r > SS_MAX) ? SS_MAX : cfg_sets_r;
  assign ways5   = {2'b00, cfg_ways_r};
  assign nw5     = (ways5 == 5'd0) ? 5'd1 : ((ways5 > WAYS5) ? WAYS5 : ways5);
  assign nw      = nw5[NW_W-1:0];

  assign shifted  = in_address >> bs;
  assign set_mask = (32'd1 << ss) - 32'd1;
  assign set32    = shifted & set_mask;
  assign tag      = in_address >> ({1'b0, bs} + {2'b00, ss});

  assign in_acc   = in_valid && in_ready;
  assign done     = (state_r == sact_pkg::ST_LOOKUP) && (!out_valid_r || out_ready);
  assign clr_last = (clr_idx_r == LAST_ROW);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sact_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = sact_pkg::ST_IDLE;
        end
      end
      sact_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = sact_pkg::ST_LOOKUP;
        end
      end
      sact_pkg::ST_LOOKUP: begin
        if (done) begin
          state_nxt = sact_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sact_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    clearing  = 1'b0;
    mem_wr_en = 1'b0;
    case (state_r)
      sact_pkg::ST_CLEAR: begin
        clearing  = 1'b1;
        mem_wr_en = 1'b1;
      end
      sact_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      sact_pkg::ST_LOOKUP: begin
        mem_wr_en = done;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign wr_addr = clearing ? clr_idx_r : set_idx_r;
  assign wr_row  = clearing ? '0 : new_row;

  sact_row_mem #(
    .MAX_SETS (MAX_SETS),
    .WAYS     (WAYS),
    .SET_W    (SET_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (set32[SET_W-1:0]),
    .rd_data (rd_row),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row)
  );

  sact_lookup #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W),
    .NW_W  (NW_W)
  ) u_lookup (
    .row_i   (rd_row),
    .tag_i   (tag_r),
    .stamp_i (acc_clk_nxt),
    .nw_i    (nw),
    .hit_o   (lk_hit),
    .way_o   (lk_way),
    .row_o   (new_row)
  );

  always_comb begin
    cfg_blk_nxt  = cfg_blk_r;
    cfg_sets_nxt = cfg_sets_r;
    cfg_ways_nxt = cfg_ways_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sact_pkg::REG_LOG2_BLOCK: cfg_blk_nxt  = cfg_data;
        sact_pkg::REG_LOG2_SETS:  cfg_sets_nxt = cfg_data[2:0];
        sact_pkg::REG_WAYS_USED:  cfg_ways_nxt = cfg_data[2:0];
        default:                  cfg_blk_nxt  = cfg_blk_r;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  assign clr_idx_nxt   = clearing ? clr_idx_r + SET_W'(1) : clr_idx_r;
  assign acc_clk_nxt   = acc_clk_r + 32'd1;
  assign hit_cnt_nxt   = (done && lk_hit) ? hit_cnt_r + 32'd1 : hit_cnt_r;
  assign miss_cnt_nxt  = (done && !lk_hit) ? miss_cnt_r + 32'd1 : miss_cnt_r;
  assign out_valid_nxt = done || (out_valid_r && !out_ready);
  assign way32         = 32'(lk_way);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sact_pkg::ST_CLEAR;
      cfg_blk_r   <= sact_pkg::RST_LOG2_BLOCK;
      cfg_sets_r  <= sact_pkg::RST_LOG2_SETS;
      cfg_ways_r  <= sact_pkg::RST_WAYS_USED;
      clr_idx_r   <= '0;
      acc_clk_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_blk_r   <= cfg_blk_nxt;
      cfg_sets_r  <= cfg_sets_nxt;
      cfg_ways_r  <= cfg_ways_nxt;
      clr_idx_r   <= clr_idx_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (done) begin
        acc_clk_r <= acc_clk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_idx_r <= set32[SET_W-1:0];
      setnum_r  <= set32[sact_pkg::SETNUM_W-1:0];
      tag_r     <= tag;
    end
    if (done) begin
      out_hit_r <= lk_hit;
      out_set_r <= setnum_r;
      out_way_r <= way32[sact_pkg::WAYNUM_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_set_number = out_set_r;
  assign out_way_used   = out_way_r;
  assign out_hit_total  = hit_cnt_r;
  assign out_miss_total = miss_cnt_r;

`ifndef SYNTHESIS
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sact_pkg::ST_CLEAR) |-> !out_valid_r)
    else $error("Result present during the clearing pass.");

  a_one_count_per_transaction: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> ((hit_cnt_r + miss_cnt_r) == ($past(hit_cnt_r + miss_cnt_r) + 32'd1)))
    else $error("Hit and miss counts did not advance by one.");

  a_counts_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(hit_cnt_r) && $stable(miss_cnt_r)))
    else $error("Counts changed while a result was stalled.");

  a_way_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (NW_W'(lk_way) < nw))
    else $error("Selected way lies outside the ways in use.");
`endif

endmodule

`default_nettype wire

// ===== sim/sact_checker.sv =====
// Checker for the cache tag store: predicts every lookup result and compares it with the block.
module sact_checker #(
  parameter int MAX_SETS = sact_pkg::DEF_MAX_SETS,
  parameter int WAYS     = sact_pkg::DEF_WAYS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [sact_pkg::ADDR_W-1:0]     in_address,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_hit,
  input  logic [sact_pkg::SETNUM_W-1:0]   out_set_number,
  input  logic [sact_pkg::WAYNUM_W-1:0]   out_way_used,
  input  logic [sact_pkg::CNT_W-1:0]      out_hit_total,
  input  logic [sact_pkg::CNT_W-1:0]      out_miss_total,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sact_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sact_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              accepted,
  output int                              checked,
  output int                              hit_results,
  output int                              errors
);

  localparam int LINES = MAX_SETS * WAYS;

  typedef struct packed {
    logic                          hit;
    logic [sact_pkg::SETNUM_W-1:0] set_number;
    logic [sact_pkg::WAYNUM_W-1:0] way_used;
    logic [sact_pkg::CNT_W-1:0]    hit_total;
    logic [sact_pkg::CNT_W-1:0]    miss_total;
  } lookup_t;

  logic                         line_ok  [LINES];
  logic [sact_pkg::TAG_W-1:0]   line_tag [LINES];
  logic [sact_pkg::STAMP_W-1:0] line_age [LINES];
  logic [sact_pkg::STAMP_W-1:0] access_clk;
  logic [sact_pkg::CNT_W-1:0]   hit_cnt;
  logic [sact_pkg::CNT_W-1:0]   miss_cnt;
  logic [3:0]                   blk_cfg;
  logic [2:0]                   sets_cfg;
  logic [2:0]                   ways_cfg;

  lookup_t lookup_results[$];

  function automatic lookup_t lru_lookup(input logic [sact_pkg::ADDR_W-1:0] addr);
    int unsigned bs;
    int unsigned ss;
    int unsigned nw;
    int unsigned set_idx;
    int unsigned base;
    int unsigned victim;
    int unsigned w;
    logic [sact_pkg::TAG_W-1:0] tag;
    bit found;
    bit done;
    lookup_t r;
    bs = (blk_cfg > sact_pkg::BLK_SHIFT_MAX) ? sact_pkg::BLK_SHIFT_MAX : blk_cfg;
    ss = sets_cfg;
    while (ss > 0 && (1 << ss) > MAX_SETS) ss--;
    nw = (ways_cfg == 0) ? 1 : ways_cfg;
    if (nw > WAYS) nw = WAYS;
    set_idx = (addr >> bs) & ((1 << ss) - 1);
    tag = addr >> (bs + ss);
    base = set_idx * WAYS;
    access_clk = access_clk + 1;
    found = 1'b0;
    victim = 0;
    for (w = 0; w < nw && !found; w++) begin
      if (line_ok[base + w] && line_tag[base + w] == tag) begin
        found = 1'b1;
        victim = w;
        line_age[base + w] = access_clk;
      end
    end
    if (found) begin
      hit_cnt = hit_cnt + 1;
    end else begin
      miss_cnt = miss_cnt + 1;
      done = 1'b0;
      for (w = 0; w < nw && !done; w++) begin
        if (!line_ok[base + w]) begin
          victim = w;
          done = 1'b1;
        end else if (line_age[base + w] < line_age[base + victim]) begin
          victim = w;
        end
      end
      line_ok[base + victim]  = 1'b1;
      line_tag[base + victim] = tag;
      line_age[base + victim] = access_clk;
    end
    r.hit        = found;
    r.set_number = sact_pkg::SETNUM_W'(set_idx);
    r.way_used   = sact_pkg::WAYNUM_W'(victim);
    r.hit_total  = hit_cnt;
    r.miss_total = miss_cnt;
    return r;
  endfunction

  function automatic int field_bad(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    int bad;
    int i;
    if (!rst_n) begin
      for (i = 0; i < LINES; i++) begin
        line_ok[i]  = 1'b0;
        line_tag[i] = '0;
        line_age[i] = '0;
      end
      access_clk = '0;
      hit_cnt    = '0;
      miss_cnt   = '0;
      blk_cfg    = sact_pkg::RST_LOG2_BLOCK;
      sets_cfg   = sact_pkg::RST_LOG2_SETS;
      ways_cfg   = sact_pkg::RST_WAYS_USED;
      lookup_results.delete();
      accepted    <= 0;
      checked     <= 0;
      hit_results <= 0;
      errors      <= 0;
    end else begin
      bad = 0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sact_pkg::REG_LOG2_BLOCK: blk_cfg = cfg_data;
          sact_pkg::REG_LOG2_SETS:  sets_cfg = cfg_data[2:0];
          sact_pkg::REG_WAYS_USED:  ways_cfg = cfg_data[2:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (lookup_results.size() == 0) begin
          $error("result with no access outstanding: hit %0d set %0d way %0d",
                 out_hit, out_set_number, out_way_used);
          bad = 1;
        end else begin
          want = lookup_results.pop_front();
          bad += field_bad("hit", want.hit, out_hit);
          bad += field_bad("set_number", want.set_number, out_set_number);
          bad += field_bad("way_used", want.way_used, out_way_used);
          bad += field_bad("hit_total", want.hit_total, out_hit_total);
          bad += field_bad("miss_total", want.miss_total, out_miss_total);
          if (want.hit) hit_results <= hit_results + 1;
        end
        checked <= checked + 1;
      end
      if (in_valid && in_ready) begin
        lookup_results.push_back(lru_lookup(in_address));
        accepted <= accepted + 1;
      end
      errors <= errors + bad;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the cache tag store: clock, reset, stimulus, register settings and verdict.
module tb_top;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int IDLE_PCT    = 26;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 1000;
  localparam int STALL_LIMIT = 20000;
  localparam logic [sact_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_valid   = 1'b0;
  logic [sact_pkg::ADDR_W-1:0]     in_address = '0;
  logic                            out_ready  = 1'b0;
  logic                            cfg_valid  = 1'b0;
  logic [sact_pkg::CFG_IDX_W-1:0]  cfg_index  = sact_pkg::REG_LOG2_BLOCK;
  logic [sact_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  logic                          in_ready;
  logic                          out_valid;
  logic                          out_hit;
  logic [sact_pkg::SETNUM_W-1:0] out_set_number;
  logic [sact_pkg::WAYNUM_W-1:0] out_way_used;
  logic [sact_pkg::CNT_W-1:0]    out_hit_total;
  logic [sact_pkg::CNT_W-1:0]    out_miss_total;
  logic                          cfg_ready;

  int accepted;
  int checked;
  int hit_results;
  int errors;

  bit          steady = 1'b0;
  int unsigned blk_shift = sact_pkg::RST_LOG2_BLOCK;
  int unsigned set_shift = sact_pkg::RST_LOG2_SETS;
  int unsigned way_count = sact_pkg::RST_WAYS_USED;
  logic [31:0] tag_base  = '0;

  set_assoc_cache_tag_lru u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_set_number (out_set_number),
    .out_way_used   (out_way_used),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  sact_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_set_number (out_set_number),
    .out_way_used   (out_way_used),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accepted       (accepted),
    .checked        (checked),
    .hit_results    (hit_results),
    .errors         (errors)
  );

  always #4 clk = ~clk;

  // The receiver stalls at random outside the steady phase, and once holds off long enough for the block to back up.
  int  results_seen = 0;
  int  hold_left    = 0;
  bit  held_once    = 1'b0;
  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!held_once && results_seen >= HOLD_AFTER) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_access(input logic [sact_pkg::ADDR_W-1:0] addr);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [sact_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sact_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (accepted != checked);
  endtask

  function automatic logic [sact_pkg::ADDR_W-1:0] place(input logic [31:0] tag,
                                                        input int unsigned set_idx);
    return (tag << (blk_shift + set_shift))
         | ((set_idx & ((1 << set_shift) - 1)) << blk_shift)
         | ($urandom & ((1 << blk_shift) - 1));
  endfunction

  initial begin
    logic [3:0] blk;
    logic [3:0] sets;
    logic [3:0] ways;
    int unsigned r;
    int unsigned set_idx;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: 64-byte blocks, 32 sets, two ways.
    send_access(32'h0000_0000);
    send_access(32'h0000_003F);
    send_access(32'hFFFF_FFFF);
    send_access(32'hFFFF_FFC0);
    send_access(32'h8000_0000);
    send_access(32'h0000_0000);
    send_access(place(32'd5, 0));
    send_access(32'h8000_0000);
    send_access(place(32'd5, 0));
    send_access(32'h0000_0000);
    send_access(32'hAAAA_AAAA);
    send_access(32'h5555_5555);
    send_access(32'h5555_5555);
    send_access(32'hAAAA_AAAA);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: begin blk = 4'd0;  sets = 4'd0; ways = 4'd1; end
          2: begin blk = 4'd12; sets = 4'd6; ways = 4'd4; end
          3: begin blk = 4'd15; sets = 4'd7; ways = 4'd7; end
          4: begin blk = 4'd13; sets = 4'd3; ways = 4'd0; end
          5: begin blk = 4'd3;  sets = 4'd2; ways = 4'd3; end
          6: begin blk = 4'd4;  sets = 4'd1; ways = 4'd5; end
          default: begin
            blk  = 4'($urandom_range(0, 15));
            sets = 4'($urandom_range(0, 15));
            ways = 4'($urandom_range(0, 15));
          end
        endcase
        write_reg(sact_pkg::REG_LOG2_BLOCK, blk);
        write_reg(sact_pkg::REG_LOG2_SETS, sets);
        write_reg(sact_pkg::REG_WAYS_USED, ways);
        if (p % 3 == 1) write_reg(REG_UNUSED, sact_pkg::CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        blk_shift = (blk > sact_pkg::BLK_SHIFT_MAX) ? sact_pkg::BLK_SHIFT_MAX : blk;
        set_shift = (sets[2:0] > $clog2(sact_pkg::DEF_MAX_SETS)) ?
                    $clog2(sact_pkg::DEF_MAX_SETS) : sets[2:0];
        way_count = (ways[2:0] == 0) ? 1 :
                    ((ways[2:0] > sact_pkg::DEF_WAYS) ? sact_pkg::DEF_WAYS : ways[2:0]);
        tag_base  = $urandom;
        steady   <= (p == 5);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_access($urandom);
        end else begin
          set_idx = (r < 55) ? $urandom_range(0, 3) : $urandom;
          send_access(place(tag_base + $urandom_range(0, way_count + 1), set_idx));
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Summary: %0d lookups checked (%0d hits, %0d misses) over %0d register settings.",
             checked, hit_results, checked - hit_results, PHASES);
    $display("Settings ranged from one set and one way up to the largest block, set and way counts.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sact_pkg.sv
hw/rtl/sact_row_mem.sv
hw/rtl/sact_lookup.sv
hw/rtl/set_assoc_cache_tag_lru.sv
sim/sact_checker.sv
sim/tb_top.sv
